// File: rtl/core/wpph_pkg.sv
// Package for the weighted pick by position hash unit.
// Holds command, status and state codes and the hash constants.
// No dependencies.
package wpph_pkg;

  typedef enum logic [1:0] {
    CMD_APPEND = 2'd0,
    CMD_PICK   = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_FULL = 2'd1,
    STAT_OVFL = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HASH,
    ST_MOD,
    ST_SEARCH,
    ST_DONE
  } top_state_e;

  typedef enum logic [2:0] {
    HS_IDLE,
    HS_MUL,
    HS_XS,
    HS_MIX,
    HS_DONE
  } hash_state_e;

  localparam logic [31:0] HASH_MUL_X = 32'h8DA6B343;
  localparam logic [31:0] HASH_MUL_Y = 32'hD8163841;
  localparam logic [31:0] HASH_MUL_Z = 32'hCB1AB31F;
  localparam logic [31:0] HASH_MIX   = 32'h2C1B3C6D;
  localparam int unsigned HASH_SHIFT_A = 15;
  localparam int unsigned HASH_SHIFT_B = 12;

  localparam logic [7:0] PICK_EMPTY_ID = 8'd1;

endpackage

// File: rtl/core/wpph_in_if.sv
// Input channel of the weighted pick by position hash unit.
// Valid/ready handshake with the command item payload. No dependencies.
interface wpph_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [7:0]  pos_x;
  logic [7:0]  pos_y;
  logic [7:0]  pos_z;
  logic [7:0]  entry_id;
  logic [24:0] entry_count;

  modport source (output valid, output cmd, output pos_x, output pos_y, output pos_z,
                  output entry_id, output entry_count, input ready);
  modport sink   (input valid, input cmd, input pos_x, input pos_y, input pos_z,
                  input entry_id, input entry_count, output ready);
endinterface

// File: rtl/core/wpph_out_if.sv
// Output channel of the weighted pick by position hash unit.
// Valid/ready handshake with the result item payload. No dependencies.
interface wpph_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [7:0] picked_entry;

  modport source (output valid, output status, output picked_entry, input ready);
  modport sink   (input valid, input status, input picked_entry, output ready);
endinterface

// File: rtl/core/weighted_pick_by_position_hash_unit.sv
// Weighted pick by position hash unit, top level.
// Depends on wpph_pkg, wpph_in_if, wpph_out_if, wpph_hash, wpph_mod, wpph_table.
//
// Usage: items arrive on item_i (valid/ready), results leave on result_o
// (valid/ready), exactly one result per item, in order. cmd 0 appends an
// entry id with its count, cmd 1 picks an entry for a voxel position, cmd 2
// clears the table; any other cmd returns status 0, picked 0.
// The block works on one item at a time. Append, clear and unused commands
// go from acceptance through the result register to the output register,
// as does a pick on an empty total. Any other pick runs the bit-serial hash
// multiplies, then the one-bit-per-cycle remainder, then the search through
// the cumulative table (one memory read per cycle, so it runs longer the
// larger the table index of the picked entry), then loads the output
// register. The next item can be accepted as soon as the previous result
// is in the output register, even if the receiver has not taken it yet; if
// the receiver stalls, the following result waits in the block and item_i
// stays not ready. Reset empties the table and the output register; table
// memory is not cleared and needs no clearing pass.
module weighted_pick_by_position_hash_unit #(
  parameter int unsigned ENTRIES = 256
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  wpph_in_if.sink  item_i,
  wpph_out_if.source result_o
);

  localparam int unsigned AW = $clog2(ENTRIES);
  localparam int unsigned FW = $clog2(ENTRIES + 1);

  wpph_pkg::top_state_e state_q, state_d;
  logic [FW-1:0] fill_q, fill_d;
  logic [31:0]   total_q, total_d;
  logic [1:0]    res_status_q, res_status_d;
  logic [7:0]    res_pick_q, res_pick_d;
  logic          ov_q;
  logic [1:0]    out_status_q;
  logic [7:0]    out_pick_q;
  logic          out_load;

  logic          accept;
  logic [32:0]   sum;
  logic          full;
  logic          wr_en;
  logic          hash_start, hash_done;
  logic [31:0]   hash_val;
  logic          mod_start, mod_done;
  logic [31:0]   mod_rem;
  logic          srch_start, srch_done;
  logic [7:0]    srch_id;

  assign item_i.ready = state_q == wpph_pkg::ST_IDLE;
  assign accept       = item_i.valid && item_i.ready;
  assign sum          = {1'b0, total_q} + {8'd0, item_i.entry_count};
  assign full         = fill_q >= FW'(ENTRIES);

  always_comb begin
    state_d      = state_q;
    fill_d       = fill_q;
    total_d      = total_q;
    res_status_d = res_status_q;
    res_pick_d   = res_pick_q;
    wr_en        = 1'b0;
    hash_start   = 1'b0;
    mod_start    = 1'b0;
    srch_start   = 1'b0;
    out_load     = 1'b0;
    case (state_q)
      wpph_pkg::ST_IDLE: begin
        if (accept) begin
          res_status_d = wpph_pkg::STAT_OK;
          res_pick_d   = '0;
          state_d      = wpph_pkg::ST_DONE;
          case (item_i.cmd)
            wpph_pkg::CMD_APPEND: begin
              if (full) begin
                res_status_d = wpph_pkg::STAT_FULL;
              end else if (sum[32]) begin
                res_status_d = wpph_pkg::STAT_OVFL;
              end else begin
                wr_en   = 1'b1;
                total_d = sum[31:0];
                fill_d  = fill_q + FW'(1);
              end
            end
            wpph_pkg::CMD_PICK: begin
              if (total_q == 32'd0) begin
                res_pick_d = wpph_pkg::PICK_EMPTY_ID;
              end else begin
                hash_start = 1'b1;
                state_d    = wpph_pkg::ST_HASH;
              end
            end
            wpph_pkg::CMD_CLEAR: begin
              fill_d  = '0;
              total_d = '0;
            end
            default: begin
            end
          endcase
        end
      end
      wpph_pkg::ST_HASH: begin
        if (hash_done) begin
          mod_start = 1'b1;
          state_d   = wpph_pkg::ST_MOD;
        end
      end
      wpph_pkg::ST_MOD: begin
        if (mod_done) begin
          srch_start = 1'b1;
          state_d    = wpph_pkg::ST_SEARCH;
        end
      end
      wpph_pkg::ST_SEARCH: begin
        if (srch_done) begin
          res_pick_d = srch_id;
          state_d    = wpph_pkg::ST_DONE;
        end
      end
      wpph_pkg::ST_DONE: begin
        if (!ov_q || result_o.ready) begin
          out_load = 1'b1;
          state_d  = wpph_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = wpph_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= wpph_pkg::ST_IDLE;
      fill_q  <= '0;
      total_q <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      total_q <= total_d;
      if (out_load) begin
        ov_q <= 1'b1;
      end else if (result_o.ready) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_status_q <= res_status_d;
    res_pick_q   <= res_pick_d;
    if (out_load) begin
      out_status_q <= res_status_q;
      out_pick_q   <= res_pick_q;
    end
  end

  assign result_o.valid        = ov_q;
  assign result_o.status       = out_status_q;
  assign result_o.picked_entry = out_pick_q;

  wpph_hash u_hash (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (hash_start),
    .pos_x_i (item_i.pos_x),
    .pos_y_i (item_i.pos_y),
    .pos_z_i (item_i.pos_z),
    .done_o  (hash_done),
    .hash_o  (hash_val)
  );

  wpph_mod u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (hash_val),
    .divisor_i  (total_q),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  wpph_table #(
    .ENTRIES (ENTRIES),
    .AW      (AW),
    .FW      (FW)
  ) u_table (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .wr_en_i      (wr_en),
    .wr_addr_i    (fill_q[AW-1:0]),
    .wr_id_i      (item_i.entry_id),
    .wr_cum_i     (sum[31:0]),
    .srch_start_i (srch_start),
    .srch_r_i     (mod_rem),
    .srch_fill_i  (fill_q),
    .srch_done_o  (srch_done),
    .srch_id_o    (srch_id)
  );

endmodule

// File: rtl/core/wpph_hash.sv
// Bit-serial position hash: three 8x32 products, one bit per cycle, then a
// 32x32 mix product, one bit per cycle. Depends on wpph_pkg.
module wpph_hash (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [7:0]  pos_x_i,
  input  logic [7:0]  pos_y_i,
  input  logic [7:0]  pos_z_i,
  output logic        done_o,
  output logic [31:0] hash_o
);

  wpph_pkg::hash_state_e state_q, state_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [7:0]  xs_q, xs_d, ys_q, ys_d, zs_q, zs_d;
  logic [31:0] ax_q, ax_d, ay_q, ay_d, az_q, az_d;
  logic [31:0] hs_q, hs_d, acc_q, acc_d;
  logic [31:0] h0;

  assign h0 = ax_q ^ ay_q ^ az_q;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    xs_d    = xs_q;
    ys_d    = ys_q;
    zs_d    = zs_q;
    ax_d    = ax_q;
    ay_d    = ay_q;
    az_d    = az_q;
    hs_d    = hs_q;
    acc_d   = acc_q;
    done_o  = 1'b0;
    case (state_q)
      wpph_pkg::HS_IDLE: begin
        if (start_i) begin
          xs_d    = pos_x_i;
          ys_d    = pos_y_i;
          zs_d    = pos_z_i;
          ax_d    = '0;
          ay_d    = '0;
          az_d    = '0;
          cnt_d   = '0;
          state_d = wpph_pkg::HS_MUL;
        end
      end
      wpph_pkg::HS_MUL: begin
        // MSB-first shift and add
        ax_d  = {ax_q[30:0], 1'b0} + (xs_q[7] ? wpph_pkg::HASH_MUL_X : 32'd0);
        ay_d  = {ay_q[30:0], 1'b0} + (ys_q[7] ? wpph_pkg::HASH_MUL_Y : 32'd0);
        az_d  = {az_q[30:0], 1'b0} + (zs_q[7] ? wpph_pkg::HASH_MUL_Z : 32'd0);
        xs_d  = {xs_q[6:0], 1'b0};
        ys_d  = {ys_q[6:0], 1'b0};
        zs_d  = {zs_q[6:0], 1'b0};
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'd7) begin
          state_d = wpph_pkg::HS_XS;
        end
      end
      wpph_pkg::HS_XS: begin
        hs_d    = h0 ^ (h0 >> wpph_pkg::HASH_SHIFT_A);
        acc_d   = '0;
        cnt_d   = '0;
        state_d = wpph_pkg::HS_MIX;
      end
      wpph_pkg::HS_MIX: begin
        acc_d = {acc_q[30:0], 1'b0} + (hs_q[31] ? wpph_pkg::HASH_MIX : 32'd0);
        hs_d  = {hs_q[30:0], 1'b0};
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          state_d = wpph_pkg::HS_DONE;
        end
      end
      wpph_pkg::HS_DONE: begin
        done_o  = 1'b1;
        state_d = wpph_pkg::HS_IDLE;
      end
      default: begin
        state_d = wpph_pkg::HS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= wpph_pkg::HS_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    xs_q  <= xs_d;
    ys_q  <= ys_d;
    zs_q  <= zs_d;
    ax_q  <= ax_d;
    ay_q  <= ay_d;
    az_q  <= az_d;
    hs_q  <= hs_d;
    acc_q <= acc_d;
  end

  assign hash_o = acc_q ^ (acc_q >> wpph_pkg::HASH_SHIFT_B);

endmodule

// File: rtl/core/wpph_mod.sv
// Restoring remainder unit: 32-bit dividend modulo a 32-bit divisor,
// one quotient bit per cycle. No dependencies.
module wpph_mod (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic        done_o,
  output logic [31:0] rem_o
);

  logic        busy_q, done_q;
  logic [4:0]  cnt_q;
  logic [31:0] a_q, d_q, rem_q;
  logic [32:0] trial, diff;
  logic        ge;

  assign trial = {rem_q, a_q[31]};
  assign diff  = trial - {1'b0, d_q};
  assign ge    = trial >= {1'b0, d_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= dividend_i;
      d_q   <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      a_q   <= {a_q[30:0], 1'b0};
      rem_q <= ge ? diff[31:0] : trial[31:0];
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

// File: rtl/core/wpph_table.sv
// Entry table: id and cumulative sum memories with one write port and one
// registered read port, plus the linear first-greater search. No dependencies.
module wpph_table #(
  parameter int unsigned ENTRIES = 256,
  parameter int unsigned AW      = $clog2(ENTRIES),
  parameter int unsigned FW      = $clog2(ENTRIES + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [7:0]    wr_id_i,
  input  logic [31:0]   wr_cum_i,
  input  logic          srch_start_i,
  input  logic [31:0]   srch_r_i,
  input  logic [FW-1:0] srch_fill_i,
  output logic          srch_done_o,
  output logic [7:0]    srch_id_o
);

  logic [7:0]  id_mem  [ENTRIES];
  logic [31:0] cum_mem [ENTRIES];

  logic [7:0]    rd_id_q;
  logic [31:0]   rd_cum_q;
  logic          busy_q, chk_q, chk_last_q, done_q;
  logic [AW-1:0] addr_q, last_q;
  logic [31:0]   r_q;
  logic [7:0]    id_q;
  logic [FW-1:0] last_full;
  logic          at_last, hit;

  assign last_full = srch_fill_i - FW'(1);
  assign at_last   = addr_q == last_q;
  assign hit       = chk_q && ((r_q < rd_cum_q) || chk_last_q);

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      id_mem[wr_addr_i]  <= wr_id_i;
      cum_mem[wr_addr_i] <= wr_cum_i;
    end
    rd_id_q  <= id_mem[addr_q];
    rd_cum_q <= cum_mem[addr_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b0;
      chk_q      <= 1'b0;
      chk_last_q <= 1'b0;
      done_q     <= 1'b0;
      addr_q     <= '0;
    end else begin
      done_q <= 1'b0;
      if (srch_start_i) begin
        busy_q <= 1'b1;
        chk_q  <= 1'b0;
        addr_q <= '0;
      end else if (busy_q) begin
        if (hit) begin
          busy_q <= 1'b0;
          chk_q  <= 1'b0;
          done_q <= 1'b1;
        end else begin
          chk_q      <= 1'b1;
          chk_last_q <= at_last;
          if (!at_last) begin
            addr_q <= addr_q + AW'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (srch_start_i) begin
      r_q    <= srch_r_i;
      last_q <= last_full[AW-1:0];
    end
    if (hit) begin
      id_q <= rd_id_q;
    end
  end

  assign srch_done_o = done_q;
  assign srch_id_o   = id_q;

endmodule
